// File: sv/mcdss_pkg.sv
// Shared sizes, codes and port structs for the drum step sequencer.
// Used by mcdss_pattern_mem and midi_clocked_drum_step_sequencer.
package mcdss_pkg;

   localparam int TRACKS  = 4;
   localparam int STEPS   = 16;
   localparam int CELLS   = TRACKS * STEPS;
   localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int STEP_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int TIDX_W  = (TRACKS > 1) ? $clog2(TRACKS) : 1;
   localparam int TCNT_W  = $clog2(TRACKS + 1);
   localparam int MSG_N   = 2 * TRACKS;

   localparam int VEL_W   = 7;
   localparam int NOTE_W  = 7;
   localparam int CHAN_W  = 4;
   localparam int TPS_W   = 6;
   localparam int SWING_W = 5;

   localparam logic [7:0] NOTE_ON_STATUS  = 8'h90;
   localparam logic [7:0] NOTE_OFF_STATUS = 8'h80;

   typedef struct packed {
      logic              en;
      logic              is_vel;
      logic [ADDR_W-1:0] addr;
      logic [VEL_W-1:0]  data;
   } pat_wr_type;

   typedef struct packed {
      logic             trig;
      logic [VEL_W-1:0] vel;
   } pat_rd_type;

endpackage

// File: sv/mcdss_pattern_mem.sv
// Pattern store: trigger and velocity memories, one write and one read port,
// registered read data; entries never written read as zero. Uses mcdss_pkg.
module mcdss_pattern_mem (
   input  logic                            clock,
   input  logic                            reset,
   input  mcdss_pkg::pat_wr_type           wr,
   input  logic [mcdss_pkg::ADDR_W-1:0]    rd_addr,
   output mcdss_pkg::pat_rd_type           rd
);
   import mcdss_pkg::*;

   logic             trig_mem [CELLS];
   logic [VEL_W-1:0] vel_mem  [CELLS];
   logic [CELLS-1:0] trig_vld_ff;
   logic [CELLS-1:0] vel_vld_ff;
   logic             trig_q_ff;
   logic [VEL_W-1:0] vel_q_ff;
   logic             trig_v_ff;
   logic             vel_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_vld_ff <= '0;
         vel_vld_ff  <= '0;
         trig_v_ff   <= 1'b0;
         vel_v_ff    <= 1'b0;
      end else begin
         if (wr.en && !wr.is_vel) begin
            trig_vld_ff[wr.addr] <= 1'b1;
         end
         if (wr.en && wr.is_vel) begin
            vel_vld_ff[wr.addr] <= 1'b1;
         end
         trig_v_ff <= trig_vld_ff[rd_addr];
         vel_v_ff  <= vel_vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && !wr.is_vel) begin
         trig_mem[wr.addr] <= wr.data[0];
      end
      if (wr.en && wr.is_vel) begin
         vel_mem[wr.addr] <= wr.data;
      end
      trig_q_ff <= trig_mem[rd_addr];
      vel_q_ff  <= vel_mem[rd_addr];
   end

   assign rd.trig = trig_q_ff & trig_v_ff;
   assign rd.vel  = vel_v_ff ? vel_q_ff : '0;

endmodule

// File: sv/midi_clocked_drum_step_sequencer.sv
// Top level of the MIDI-clocked drum step sequencer with swing.
// Uses mcdss_pkg and mcdss_pattern_mem.
//
// req_*: one real-time event or pattern write per item; the kind is in req_tuser.
// rsp_*: one 3-byte MIDI note message per item; rsp_tlast marks the last message
//        caused by one request item.
// csr_*: register writes (0 ticks_per_step, 1 midi_channel, 2..5 track notes),
//        taken only while the block is idle; csr_ready is low while busy.
// Start, swing, pattern writes and clock pulses that fire no step leave the block
// idle and may follow back to back. A clock pulse that fires a step reads the
// pattern memory once per track (TRACKS reads, one after another on the single
// registered read port), then sends up to 2*TRACKS messages: a note-off for each
// pending note and a note-on for each track that triggers; the next item is taken
// only after the last message is placed in the output register.
// req_tready is low while busy.
// A stalled receiver holds the output register; the block still finishes an event
// and takes new items once its last message sits in the output register.
// Reset clears counters, pending note-offs, swing and the pattern valid bits at
// once; no clearing pass is needed.
module midi_clocked_drum_step_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // track[1:0], step[5:2], value[12:6], zero[15:13]
   input  logic [2:0]  req_tuser,  // op[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // status_byte[7:0], note[14:8], velocity_out[21:15]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [6:0]  csr_data
);
   import mcdss_pkg::*;

   localparam int AW1 = ADDR_W + 1;

   localparam logic [2:0] OP_START = 3'd0;
   localparam logic [2:0] OP_CLOCK = 3'd1;
   localparam logic [2:0] OP_SWING = 3'd2;
   localparam logic [2:0] OP_TRIG  = 3'd3;
   localparam logic [2:0] OP_VEL   = 3'd4;

   localparam logic [2:0] CSR_TPS   = 3'd0;
   localparam logic [2:0] CSR_CHAN  = 3'd1;
   localparam logic [2:0] CSR_NOTE0 = 3'd2;
   localparam logic [2:0] CSR_NOTE3 = 3'd5;

   typedef enum logic [1:0] {S_IDLE, S_READ, S_EMIT} state_type;

   state_type            state_ff, state_in;
   logic [5:0]           tick_ff, tick_in;
   logic [STEP_W-1:0]    pos_ff, pos_in;
   logic [STEP_W-1:0]    fpos_ff, fpos_in;
   logic [TRACKS-1:0]    pend_ff, pend_in;
   logic [SWING_W-1:0]   swing_ff, swing_in;
   logic [TCNT_W-1:0]    cnt_ff, cnt_in;
   logic [TRACKS-1:0]    trig_cap_ff, trig_cap_in;
   logic [VEL_W-1:0]     vel_cap_ff [TRACKS];
   logic [MSG_N-1:0]     done_ff, done_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [23:0]          rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [TPS_W-1:0]     tps_ff;
   logic [CHAN_W-1:0]    chan_ff;
   logic [NOTE_W-1:0]    note_ff [4];

   logic [2:0]           op;
   logic [1:0]           in_trk;
   logic [3:0]           in_stp;
   logic [6:0]           in_val;
   logic                 accept;
   logic [TPS_W-1:0]     tps_eff;
   logic [6:0]           swing_tick;
   logic [6:0]           wrap_tick;
   logic                 fire;
   logic                 wrap;
   logic                 cap_en;
   logic [TIDX_W-1:0]    cap_idx;
   logic [MSG_N-1:0]     want;
   logic [MSG_N-1:0]     remain;
   logic [MSG_N-1:0]     sel_hot;
   logic [TIDX_W-1:0]    sel_trk;
   logic                 sel_on;
   logic                 found;
   logic                 rsp_free;
   logic [NOTE_W-1:0]    sel_note;
   logic [7:0]           sel_status;
   logic [VEL_W-1:0]     sel_vel;

   pat_wr_type           pat_wr;
   pat_rd_type           pat_rd;
   logic [ADDR_W-1:0]    rd_addr;

   mcdss_pattern_mem u_pattern (
      .clock   (clock),
      .reset   (reset),
      .wr      (pat_wr),
      .rd_addr (rd_addr),
      .rd      (pat_rd)
   );

   assign op     = req_tuser;
   assign in_trk = req_tdata[1:0];
   assign in_stp = req_tdata[5:2];
   assign in_val = req_tdata[12:6];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = (state_ff == S_IDLE);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      if (tps_ff == '0) begin
         tps_eff = TPS_W'(1);
      end else if (tps_ff > TPS_W'(32)) begin
         tps_eff = TPS_W'(32);
      end else begin
         tps_eff = tps_ff;
      end
   end

   assign swing_tick = 7'(tps_eff) + 7'(swing_ff);
   assign wrap_tick  = 7'({tps_eff, 1'b0}) - 7'd1;
   assign fire       = (tick_ff == '0) || (7'(tick_ff) == swing_tick);
   assign wrap       = 7'(tick_ff) >= wrap_tick;

   assign rd_addr = ADDR_W'(AW1'(cnt_ff[TIDX_W-1:0]) * AW1'(STEPS) + AW1'(fpos_ff));
   assign cap_idx = TIDX_W'(cnt_ff - TCNT_W'(1));

   always_comb begin
      for (int t = 0; t < TRACKS; t++) begin
         want[2*t]     = pend_ff[t];
         want[2*t + 1] = trig_cap_ff[t];
      end
   end

   assign remain = want & ~done_ff;

   always_comb begin
      found   = 1'b0;
      sel_hot = '0;
      sel_trk = '0;
      sel_on  = 1'b0;
      for (int k = 0; k < MSG_N; k++) begin
         if (remain[k] && !found) begin
            found      = 1'b1;
            sel_hot[k] = 1'b1;
            sel_trk    = TIDX_W'(k >> 1);
            sel_on     = ((k & 1) != 0);
         end
      end
   end

   assign sel_note   = note_ff[2'(sel_trk)];
   assign sel_status = (sel_on ? NOTE_ON_STATUS : NOTE_OFF_STATUS) | 8'(chan_ff);
   assign sel_vel    = sel_on ? vel_cap_ff[sel_trk] : '0;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      pos_in       = pos_ff;
      fpos_in      = fpos_ff;
      pend_in      = pend_ff;
      swing_in     = swing_ff;
      cnt_in       = cnt_ff;
      trig_cap_in  = trig_cap_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      cap_en       = 1'b0;
      pat_wr       = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (op)
                  OP_START: begin
                     tick_in = '0;
                     pos_in  = '0;
                     pend_in = '0;
                  end
                  OP_CLOCK: begin
                     tick_in = wrap ? '0 : tick_ff + 6'd1;
                     if (fire) begin
                        fpos_in  = pos_ff;
                        pos_in   = (pos_ff == STEP_W'(STEPS - 1)) ? '0 : pos_ff + STEP_W'(1);
                        cnt_in   = '0;
                        state_in = S_READ;
                     end
                  end
                  OP_SWING: begin
                     swing_in = (in_val > 7'd31) ? 5'd31 : in_val[4:0];
                  end
                  OP_TRIG, OP_VEL: begin
                     if (int'(in_trk) < TRACKS && int'(in_stp) < STEPS) begin
                        pat_wr.en     = 1'b1;
                        pat_wr.is_vel = (op == OP_VEL);
                        pat_wr.addr   = ADDR_W'(AW1'(in_trk) * AW1'(STEPS) + AW1'(in_stp));
                        pat_wr.data   = in_val;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            cnt_in = cnt_ff + TCNT_W'(1);
            if (cnt_ff != '0) begin
               cap_en               = 1'b1;
               trig_cap_in[cap_idx] = pat_rd.trig;
            end
            if (cnt_ff == TCNT_W'(TRACKS)) begin
               done_in  = '0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (remain == '0) begin
               pend_in  = trig_cap_ff;
               state_in = S_IDLE;
            end else if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, sel_vel, sel_note, sel_status};
               rsp_last_in  = ((remain & ~sel_hot) == '0);
               done_in      = done_ff | sel_hot;
               if ((remain & ~sel_hot) == '0) begin
                  pend_in  = trig_cap_ff;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tick_ff      <= '0;
         pos_ff       <= '0;
         pend_ff      <= '0;
         swing_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         pos_ff       <= pos_in;
         pend_ff      <= pend_in;
         swing_ff     <= swing_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fpos_ff     <= fpos_in;
      trig_cap_ff <= trig_cap_in;
      done_ff     <= done_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (cap_en) begin
         vel_cap_ff[cap_idx] <= pat_rd.vel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff     <= TPS_W'(6);
         chan_ff    <= '0;
         note_ff[0] <= NOTE_W'(42);
         note_ff[1] <= NOTE_W'(56);
         note_ff[2] <= NOTE_W'(38);
         note_ff[3] <= NOTE_W'(36);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TPS: begin
               tps_ff <= csr_data[TPS_W-1:0];
            end
            CSR_CHAN: begin
               chan_ff <= csr_data[CHAN_W-1:0];
            end
            default: begin
               if (csr_index inside {[CSR_NOTE0:CSR_NOTE3]}) begin
                  note_ff[2'(csr_index - CSR_NOTE0)] <= csr_data;
               end
            end
         endcase
      end
   end

endmodule
